@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/upc_pkg.sv @@
// Types, constants and character classification functions of the percent codec.
package upc_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam int unsigned ENTRY_BYTES = 3;

	// Escape phase of the decoder.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One queue entry: up to three output bytes produced by one input byte.
	typedef struct packed {
		logic [1:0]                   cnt;
		logic                         last;
		logic [ENTRY_BYTES-1:0][7:0]  bytes;
	} entry_t;

	// Uppercase hex digit for a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		begin
			if (nib < 4'hA) begin
				c = 8'h30 + {4'h0, nib};
			end else begin
				c = 8'h41 + {4'h0, nib - 4'hA};
			end
			return c;
		end
	endfunction

	// True for a byte that encoding must escape.
	function automatic logic needs_escape(input logic [7:0] b);
		logic r;
		begin
			unique case (b) inside
				8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C,
				8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
				8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D: r = 1'b1;
				default: r = (b < 8'h20) || (b > 8'h7E);
			endcase
			return r;
		end
	endfunction

	// True for a hex digit character of either case.
	function automatic logic is_hex(input logic [7:0] b);
		logic r;
		begin
			unique case (b) inside
				[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	// Value of a hex digit character; meaningful only where is_hex holds.
	function automatic logic [3:0] hex_nib(input logic [7:0] b);
		logic [3:0] v;
		begin
			if (b <= 8'h39) begin
				v = b[3:0];
			end else begin
				v = b[3:0] + 4'h9;
			end
			return v;
		end
	endfunction

endpackage

@@ hw/rtl/upc_front.sv @@
// Front end: mode register, escape state and classification of each input byte.
module upc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                q_full,
	output logic                in_stall,
	output logic                push,
	output upc_pkg::entry_t     push_entry
);

	logic             mode_q;
	upc_pkg::phase_t  phase_q;
	upc_pkg::phase_t  phase_d;
	logic [7:0]       held_q;
	logic             accept;
	logic             b_hex;
	logic             b_pct;
	logic             hold_digit;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b_hex    = upc_pkg::is_hex(in_byte);
	assign b_pct    = (in_byte == upc_pkg::PCT_CHAR) && !in_last;

	// Next escape phase.
	always_comb begin
		phase_d = upc_pkg::PH_IDLE;
		if (mode_q) begin
			unique case (phase_q)
				upc_pkg::PH_PCT: begin
					if (b_hex && !in_last) begin
						phase_d = upc_pkg::PH_DIGIT;
					end else if (b_pct) begin
						phase_d = upc_pkg::PH_PCT;
					end
				end
				upc_pkg::PH_DIGIT: begin
					if (!b_hex && b_pct) begin
						phase_d = upc_pkg::PH_PCT;
					end
				end
				default: begin
					if (b_pct) begin
						phase_d = upc_pkg::PH_PCT;
					end
				end
			endcase
		end
	end

	// Output bytes for this input byte.
	always_comb begin
		push_entry.last  = in_last;
		push_entry.cnt   = 2'd1;
		push_entry.bytes = '0;
		hold_digit       = 1'b0;
		if (!mode_q) begin
			if (upc_pkg::needs_escape(in_byte)) begin
				push_entry.cnt      = 2'd3;
				push_entry.bytes[0] = upc_pkg::PCT_CHAR;
				push_entry.bytes[1] = upc_pkg::hex_char(in_byte[7:4]);
				push_entry.bytes[2] = upc_pkg::hex_char(in_byte[3:0]);
			end else begin
				push_entry.bytes[0] = in_byte;
			end
		end else begin
			unique case (phase_q)
				upc_pkg::PH_PCT: begin
					push_entry.bytes[0] = upc_pkg::PCT_CHAR;
					push_entry.bytes[1] = in_byte;
					if (b_hex && !in_last) begin
						push_entry.cnt = 2'd0;
						hold_digit     = 1'b1;
					end else if (b_pct) begin
						push_entry.cnt = 2'd1;
					end else begin
						push_entry.cnt = 2'd2;
					end
				end
				upc_pkg::PH_DIGIT: begin
					if (b_hex) begin
						push_entry.bytes[0] = {upc_pkg::hex_nib(held_q),
							upc_pkg::hex_nib(in_byte)};
					end else begin
						push_entry.bytes[0] = upc_pkg::PCT_CHAR;
						push_entry.bytes[1] = held_q;
						push_entry.bytes[2] = in_byte;
						push_entry.cnt      = b_pct ? 2'd2 : 2'd3;
					end
				end
				default: begin
					push_entry.bytes[0] = in_byte;
					push_entry.cnt      = b_pct ? 2'd0 : 2'd1;
				end
			endcase
		end
	end

	// Bytes that produce nothing leave no queue entry.
	assign push = accept && (push_entry.cnt != 2'd0);

	// Mode register and escape state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= upc_pkg::PH_IDLE;
			held_q  <= 8'h00;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				phase_q <= phase_d;
				if (hold_digit) begin
					held_q <= in_byte;
				end
			end
		end
	end

endmodule

@@ hw/rtl/upc_queue.sv @@
// Short queue of output entries between the front and back ends.
module upc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  upc_pkg::entry_t  push_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output upc_pkg::entry_t  head_entry
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	upc_pkg::entry_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/upc_back.sv @@
// Back end: walks the bytes of the head entry into the output register.
module upc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  upc_pkg::entry_t  head_entry,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [1:0]  idx_q;
	logic        load;
	logic        at_end;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// The output register takes a new beat when empty or being drained.
	assign load   = head_valid && (!out_valid_q || !out_stall);
	assign at_end = (idx_q == head_entry.cnt - 2'd1);
	assign pop    = load && at_end;

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_entry.bytes[idx_q];
			out_last_q <= head_entry.last && at_end;
		end
	end

	// Output valid and byte index within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/url_percent_codec.sv @@
// Streaming URL percent encoder and decoder, one string byte per input beat.
// The output bytes of an accepted input byte are registered in the entry queue and then in the output register.
// Throughput: one input beat per cycle while the entry queue has room; the output side
// moves one byte per cycle while out_stall is low, so an escaped byte in encode mode occupies it for all three bytes.
// Reset: arst_n clears the mode to encode, the escape state and the queue, and drops out_valid.
module url_percent_codec #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	logic             push;
	upc_pkg::entry_t  push_entry;
	logic             q_full;
	logic             head_valid;
	upc_pkg::entry_t  head_entry;
	logic             pop;

	// The mode register takes a beat in any cycle.
	assign cfg_ready = 1'b1;

	upc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	upc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

@@ hw/rtl/upc_checker.sv @@
// Port-level checker for the percent codec and its bind to the top level.
`include "assert_macros.svh"

module upc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        out_last
);

	logic [7:0]  open_strings_q;
	logic        in_end_beat;
	logic        out_end_beat;

	assign in_end_beat  = in_valid && !in_stall && in_last;
	assign out_end_beat = out_valid && !out_stall && out_last;

	// Strings whose last input beat is accepted but whose last output beat is not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_strings_q <= 8'd0;
		end else if (in_end_beat && !out_end_beat) begin
			open_strings_q <= open_strings_q + 8'd1;
		end else if (out_end_beat && !in_end_beat) begin
			open_strings_q <= open_strings_q - 8'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last), "stalled output beat changed")
	`ASSERT_IMPLIES(a_last_has_string, clk, arst_n, out_end_beat, open_strings_q != 8'd0, "out_last with no string ended at the input")
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n, !out_valid, "out_valid high during reset")
	`ASSERT_IMPLIES(a_drop_after_beat, clk, arst_n, $fell(out_valid), $past(!out_stall), "output beat dropped while stalled")

endmodule

bind url_percent_codec upc_checker u_upc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_last   (in_last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.out_last  (out_last)
);

@@ test/tb_url_percent_codec.sv @@
// Self-checking testbench for the URL percent codec, with directed and random strings in both modes.
`timescale 1ns / 1ps

module tb_url_percent_codec;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES_PER_MODE = 76;
	localparam int TIMEOUT_NS = 8_000_000;
	localparam int NO_DIGIT = 16;
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;
	localparam logic [7:0] PCT_CHAR = upc_pkg::PCT_CHAR;
	localparam logic [8*16-1:0] HEX_UPPER = "0123456789ABCDEF";

	// One output beat as the codec should deliver it.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_MODE
	} row_kind_t;

	// One row of the directed table. Typed rows carry their output bytes, e0 first.
	typedef struct packed {
		row_kind_t  kind;
		logic       mode_val;
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic [1:0] n_exp;
		logic [7:0] e0;
		logic [7:0] e1;
		logic [7:0] e2;
	} stim_row_t;

	localparam int N_ROWS = 31;
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		// Encode after reset: pass-through, both byte extremes and the upper printable edge.
		'{ROW_BYTE, MODE_ENCODE, 8'h41, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h00, 1'b0, 1'b1, 2'd3, PCT_CHAR, 8'h30, 8'h30},
		'{ROW_BYTE, MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 2'd3, PCT_CHAR, 8'h46, 8'h46},
		'{ROW_BYTE, MODE_ENCODE, 8'h7E, 1'b0, 1'b1, 2'd1, 8'h7E, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h7F, 1'b0, 1'b1, 2'd3, PCT_CHAR, 8'h37, 8'h46},
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b1, 1'b1, 2'd3, PCT_CHAR, 8'h32, 8'h35},
		// Decode: a complete escape whose last digit ends the string.
		'{ROW_MODE, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h34, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h31, 1'b1, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
		// Lowercase and uppercase digits in one escape.
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h66, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h46, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		// A non-digit after the percent sign releases the percent sign.
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h47, 1'b0, 1'b1, 2'd2, PCT_CHAR, 8'h47, 8'h00},
		// A second percent sign releases the first and opens a new escape.
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00},
		// A bad third character releases the percent sign, the digit and itself.
		'{ROW_BYTE, MODE_ENCODE, 8'h33, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h7A, 1'b0, 1'b1, 2'd3, PCT_CHAR, 8'h33, 8'h7A},
		// The end of the string flushes a pending escape; a bare percent sign ends one.
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h61, 1'b1, 1'b1, 2'd2, PCT_CHAR, 8'h61, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b1, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00},
		// Switching to encode with an escape pending drops the escape.
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_MODE, MODE_ENCODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h20, 1'b1, 1'b1, 2'd3, PCT_CHAR, 8'h32, 8'h30},
		// Mode writes alone leave a pending escape in place.
		'{ROW_MODE, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_MODE, MODE_ENCODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_MODE, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h34, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
		'{ROW_BYTE, MODE_ENCODE, 8'h31, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	// Shadow state of the codec and the output beats still owed by it.
	logic             codec_mode = MODE_ENCODE;
	upc_pkg::phase_t  esc_phase = upc_pkg::PH_IDLE;
	logic [7:0]       held_char = 8'h00;
	logic [7:0]       step_bytes [$];
	out_beat_t        pending_out [$];

	int unsigned send_idle_pct = 34;
	int unsigned recv_stall_pct = 71;
	int unsigned bytes_sent = 0;
	int unsigned strings_sent = 0;
	int unsigned mode_writes = 0;
	int unsigned bytes_checked = 0;
	int unsigned mismatches = 0;

	url_percent_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Bytes that encoding turns into an escape: the reserved set and all non-printables.
	function automatic logic escapes_on_encode(input logic [7:0] b);
		return (b < 8'h20) || (b > 8'h7E) ||
			(b inside {8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C,
				8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
				8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D});
	endfunction

	function automatic logic [7:0] upper_hex(input logic [3:0] nib);
		return HEX_UPPER[8 * (15 - nib) +: 8];
	endfunction

	// Weight of a hex digit of either case, or NO_DIGIT for any other byte.
	function automatic int digit_weight(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
		return NO_DIGIT;
	endfunction

	// Appends one byte to the output of the current step.
	function automatic void emit_byte(input logic [7:0] b);
		step_bytes.insert(step_bytes.size(), b);
	endfunction

	// A byte seen with no escape open: a percent sign opens one unless the string ends.
	function automatic void take_plain(input logic [7:0] b, input logic l);
		if (b == PCT_CHAR && !l) begin
			esc_phase = upc_pkg::PH_PCT;
		end else begin
			emit_byte(b);
		end
	endfunction

	// Advances the shadow state by one input byte and leaves its output in step_bytes.
	function automatic void codec_step(input logic [7:0] b, input logic l);
		upc_pkg::phase_t prior;
		int     lo;
		int     hi;
		prior = esc_phase;
		esc_phase = upc_pkg::PH_IDLE;
		step_bytes.delete();
		if (codec_mode == MODE_ENCODE) begin
			if (escapes_on_encode(b)) begin
				emit_byte(PCT_CHAR);
				emit_byte(upper_hex(b[7:4]));
				emit_byte(upper_hex(b[3:0]));
			end else begin
				emit_byte(b);
			end
		end else if (prior == upc_pkg::PH_PCT) begin
			if (digit_weight(b) != NO_DIGIT && !l) begin
				held_char = b;
				esc_phase = upc_pkg::PH_DIGIT;
			end else begin
				emit_byte(PCT_CHAR);
				take_plain(b, l);
			end
		end else if (prior == upc_pkg::PH_DIGIT) begin
			lo = digit_weight(b);
			if (lo != NO_DIGIT) begin
				hi = digit_weight(held_char);
				emit_byte(8'(hi * 16 + lo));
			end else begin
				emit_byte(PCT_CHAR);
				emit_byte(held_char);
				take_plain(b, l);
			end
		end else begin
			take_plain(b, l);
		end
		if (l) begin
			esc_phase = upc_pkg::PH_IDLE;
		end
	endfunction

	function automatic logic [7:0] random_hex_char();
		int unsigned v;
		v = $urandom_range(15);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	// Offers one input beat, after a random gap, and books the output it owes.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
			input logic [1:0] n_typed, input logic [2:0][7:0] typed_bytes);
		int        n;
		out_beat_t beat;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (in_stall);
		codec_step(b, l);
		if (typed) begin
			step_bytes.delete();
			for (int i = 0; i < n_typed; i++) emit_byte(typed_bytes[2 - i]);
		end
		n = step_bytes.size();
		for (int i = 0; i < n; i++) begin
			beat.data = step_bytes[i];
			beat.last = l && (i == n - 1);
			pending_out.insert(pending_out.size(), beat);
		end
		bytes_sent++;
	endtask

	// Holds the input side until every owed beat has come out and the pipeline is quiet.
	task automatic wait_codec_idle();
		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic value);
		wait_codec_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		codec_mode = value;
		mode_writes++;
	endtask

	// Builds one string suited to the current mode and sends it, flagging its last byte.
	task automatic send_random_string();
		logic [7:0]  text [$];
		int unsigned target_len;
		int unsigned pick;
		target_len = $urandom_range(10, 1);
		while (text.size() < target_len) begin
			pick = $urandom_range(99);
			if (codec_mode == MODE_ENCODE) begin
				if (pick < 55) begin
					text.insert(text.size(), 8'($urandom_range(255)));
				end else begin
					text.insert(text.size(), 8'($urandom_range(8'h7E, 8'h20)));
				end
			end else if (pick < 45) begin
				// Well-formed escape with digits of mixed case.
				text.insert(text.size(), PCT_CHAR);
				text.insert(text.size(), random_hex_char());
				text.insert(text.size(), random_hex_char());
			end else if (pick < 60) begin
				// Percent sign and zero or one digit, then an arbitrary byte that may break the escape off.
				text.insert(text.size(), PCT_CHAR);
				if ($urandom_range(1)) text.insert(text.size(), random_hex_char());
				text.insert(text.size(), 8'($urandom_range(255)));
			end else if (pick < 70) begin
				text.insert(text.size(), PCT_CHAR);
			end else if (pick < 90) begin
				text.insert(text.size(), 8'($urandom_range(8'h7E, 8'h20)));
			end else begin
				text.insert(text.size(), 8'($urandom_range(255)));
			end
		end
		for (int i = 0; i < text.size(); i++) begin
			send_byte(text[i], i == text.size() - 1, 1'b0, 2'd0, '0);
		end
		strings_sent++;
	endtask

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every output beat must match the oldest owed beat, field by field.
	always @(posedge clk) begin : out_check
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				$display("%0t: output beat with nothing owed: expected none, actual byte %h last %b",
					$time, out_byte, out_last);
				mismatches++;
			end else begin
				want = pending_out.pop_front();
				bytes_checked++;
				if (out_byte !== want.data) begin
					$display("%0t: out_byte mismatch: expected %h, actual %h",
						$time, want.data, out_byte);
					mismatches++;
				end
				if (out_last !== want.last) begin
					$display("%0t: out_last mismatch: expected %b, actual %b",
						$time, want.last, out_last);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t   row;
		int unsigned start_count;
		// Assert reset once every process waits on it, so the codec sees the falling edge.
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, run under the first idle pattern.
		for (int i = 0; i < N_ROWS; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_MODE) begin
				write_mode(row.mode_val);
			end else begin
				send_byte(row.data, row.last, row.typed, row.n_exp, {row.e0, row.e1, row.e2});
			end
		end

		// Random strings: three idle patterns, each with a stretch in both modes.
		for (int ph = 0; ph < 3; ph++) begin
			for (int half = 0; half < 2; half++) begin
				write_mode(((ph + half) % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
				if (half == 0) begin
					case (ph)
						0: begin
							send_idle_pct = 34;
							recv_stall_pct = 71;
						end
						1: begin
							send_idle_pct = 71;
							recv_stall_pct = 34;
						end
						default: begin
							send_idle_pct = 0;
							recv_stall_pct = 0;
						end
					endcase
				end
				start_count = bytes_sent;
				while (bytes_sent - start_count < RANDOM_BYTES_PER_MODE) send_random_string();
			end
		end

		wait_codec_idle();
		$display("Run covered %0d input bytes (%0d random strings) and %0d mode writes,",
			bytes_sent, strings_sent, mode_writes);
		$display("under three idle patterns; %0d output bytes checked, %0d mismatches.",
			bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout with %0d output beats still owed.", pending_out.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/upc_pkg.sv
hw/rtl/upc_front.sv
hw/rtl/upc_queue.sv
hw/rtl/upc_back.sv
hw/rtl/url_percent_codec.sv
hw/rtl/upc_checker.sv
test/tb_url_percent_codec.sv
